### rtl/rtcos_pkg.sv
// ----------------------------------------------------------------------------
// rtcos_pkg
// Shared types and constants for the round-trip clock offset sync unit.
// ----------------------------------------------------------------------------
package rtcos_pkg;

    localparam logic [63:0] MAX_HOST_NS    = 64'd2147483647999999999;
    localparam logic [63:0] LOCAL_US_LIMIT = 64'd9223372036854775;
    localparam int          HOST_TIME_W    = 61;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ACCEPT = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic {
        CFG_MAX_RTT_US = 1'b0,
        CFG_SYNC_TIMEOUT_US = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        loc_us;
        logic signed [63:0] echo_us;
        logic signed [63:0] hrx_ns;
        logic signed [63:0] htx_ns;
    } t_in_beat;

    typedef struct packed {
        logic                   ok;
        logic [HOST_TIME_W-1:0] host_time_ns;
    } t_out_beat;

    // Stateless terms of one input beat, held in the input register.
    typedef struct packed {
        t_op         op;
        logic [63:0] loc_us;
        logic [63:0] echo_us;
        logic [63:0] loc_ns;
        logic [63:0] proc_ns;
        logic [63:0] send_minus_local;
        logic [63:0] send_headroom;
        logic        local_ok;
        logic        host_ok;
    } t_prep;

endpackage

### rtl/rtcos_prep.sv
// ----------------------------------------------------------------------------
// rtcos_prep
// Stateless front end: scales local time to ns and checks host stamps.
// ----------------------------------------------------------------------------
module rtcos_prep (
    input  rtcos_pkg::t_in_beat i_beat,
    output rtcos_pkg::t_prep    o_prep
);
    import rtcos_pkg::*;

    logic signed [63:0] hrx;
    logic signed [63:0] htx;
    logic [63:0]        loc_ns;

    assign hrx = $signed(i_beat.hrx_ns);
    assign htx = $signed(i_beat.htx_ns);

    // x * 1000 = x * 1024 - x * 16 - x * 8
    assign loc_ns = (i_beat.loc_us << 10) - (i_beat.loc_us << 4)
                  - (i_beat.loc_us << 3);

    always_comb begin
        o_prep.op               = t_op'(i_beat.op);
        o_prep.loc_us           = i_beat.loc_us;
        o_prep.echo_us          = i_beat.echo_us;
        o_prep.loc_ns           = loc_ns;
        o_prep.proc_ns          = htx - hrx;
        o_prep.send_minus_local = htx - loc_ns;
        o_prep.send_headroom    = MAX_HOST_NS - htx;
        o_prep.local_ok         = i_beat.loc_us <= LOCAL_US_LIMIT;
        o_prep.host_ok          = !i_beat.echo_us[63] && (hrx > 64'sd0)
                                && (htx >= hrx) && (htx <= $signed(MAX_HOST_NS));
    end

endmodule

### rtl/round_trip_clock_offset_sync_unit.sv
// ----------------------------------------------------------------------------
// round_trip_clock_offset_sync_unit
// Host clock offset estimation from one request/response exchange per sync.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the input register is free or moving on. A
// result is offered once its beat has passed the input register, where local
// time is already scaled to ns and the host stamps are checked, and then the
// evaluation stage, which reads and updates the sync state and loads the
// result register. Each beat sees the state left by the beat before it.
// Back pressure on the output stalls the evaluation stage; the input side
// keeps taking beats while that stage is free.
module round_trip_clock_offset_sync_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rtcos_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rtcos_pkg::t_out_beat o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    import rtcos_pkg::*;

    t_prep       prep;
    t_prep       r_s1;
    logic        r_s1_valid;
    logic        r_out_valid;
    t_out_beat   r_out;
    logic        s1_fire;

    logic [31:0] r_max_rtt_us;
    logic [63:0] r_sync_tmo_us;
    logic [63:0] r_req_us;
    logic [63:0] r_req_ns;
    logic        r_pending;
    logic [63:0] r_ofs_ns;
    logic [63:0] r_last_sync_us;
    logic        r_synced;

    logic [63:0] elapsed_us;
    logic [63:0] rtt_ns;
    logic [63:0] net_ns;
    logic [63:0] half_ns;
    logic        accept_ok;
    logic [63:0] age_us;
    logic [64:0] est_ns;
    logic        query_ok;
    t_out_beat   n_out;

    rtcos_prep u_prep (
        .i_beat (i_in_data),
        .o_prep (prep)
    );

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign elapsed_us = r_s1.loc_us - r_req_us;
    assign rtt_ns     = r_s1.loc_ns - r_req_ns;
    assign net_ns     = rtt_ns - r_s1.proc_ns;
    assign half_ns    = {1'b0, net_ns[63:1]};

    assign accept_ok = r_pending && r_s1.host_ok && r_s1.local_ok
                     && (r_s1.echo_us == r_req_us)
                     && (r_s1.loc_us >= r_req_us)
                     && (elapsed_us <= {32'd0, r_max_rtt_us})
                     && (r_s1.proc_ns <= rtt_ns)
                     && (half_ns <= r_s1.send_headroom);

    assign age_us   = r_s1.loc_us - r_last_sync_us;
    assign est_ns   = {1'b0, r_s1.loc_ns} + {r_ofs_ns[63], r_ofs_ns};
    assign query_ok = r_synced && r_s1.local_ok
                    && (r_s1.loc_us >= r_last_sync_us)
                    && (age_us < r_sync_tmo_us)
                    && !est_ns[64] && (est_ns[63:0] <= MAX_HOST_NS);

    always_comb begin
        n_out = '0;
        case (r_s1.op)
            OP_START:  n_out.ok = 1'b1;
            OP_ACCEPT: n_out.ok = accept_ok;
            OP_QUERY: begin
                n_out.ok = query_ok;
                if (query_ok) begin
                    n_out.host_time_ns = est_ns[HOST_TIME_W-1:0];
                end
            end
            default:   n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_max_rtt_us   <= '0;
            r_sync_tmo_us  <= '0;
            r_req_us       <= '0;
            r_req_ns       <= '0;
            r_pending      <= 1'b0;
            r_ofs_ns       <= '0;
            r_last_sync_us <= '0;
            r_synced       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_RTT_US:      r_max_rtt_us  <= i_cfg_data[31:0];
                    CFG_SYNC_TIMEOUT_US: r_sync_tmo_us <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                case (r_s1.op)
                    OP_START: begin
                        r_req_us  <= r_s1.loc_us;
                        r_req_ns  <= r_s1.loc_ns;
                        r_pending <= 1'b1;
                    end
                    OP_ACCEPT: begin
                        if (accept_ok) begin
                            r_ofs_ns       <= r_s1.send_minus_local + half_ns;
                            r_last_sync_us <= r_s1.loc_us;
                            r_synced       <= 1'b1;
                            r_pending      <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= prep;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/rtcos_checker.sv
// ----------------------------------------------------------------------------
// rtcos_checker
// Port-level checks for the round-trip clock offset sync unit.
// ----------------------------------------------------------------------------
module rtcos_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input rtcos_pkg::t_out_beat o_out_data
);
    import rtcos_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    a_time_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> o_out_data.host_time_ns == '0)
        else $error("host time given on a rejected beat");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {3'b000, o_out_data.host_time_ns} <= MAX_HOST_NS)
        else $error("host time above limit");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind round_trip_clock_offset_sync_unit rtcos_checker u_rtcos_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-trip clock offset sync unit. A short
// stimulus table covers the reject paths, the extremes of the host stamps
// and the timeout edge. Random request/response exchanges with follow-up
// queries come next, mixed with random noise beats. The run steps through
// several register settings and several idle patterns. Each result is checked
// field by field against the table's expected value or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import rtcos_pkg::*;

    localparam int                 HOLD_CYCLES    = 300;
    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 PHASE_BEATS    = 100;
    localparam logic signed [63:0] HOST_NS_TOP    = MAX_HOST_NS;
    localparam logic signed [63:0] INT_NS_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_row;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    t_in_beat    in_beat  = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we   = 1'b0;
    t_cfg_idx    cfg_idx  = CFG_MAX_RTT_US;
    logic [63:0] cfg_data = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_beat   out_beat;

    // sync state mirror
    logic [63:0]        req_us;
    logic               req_open;
    logic signed [63:0] ofs_ns;
    logic [63:0]        sync_us;
    logic               synced;
    logic [31:0]        rtt_us;
    logic [63:0]        tmo_us;

    t_out_beat awaited[$];
    t_out_beat due;
    t_row      script[$];
    int        fail_count   = 0;
    int        beats_sent   = 0;
    int        idle_cycles  = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req     = 1'b0;
    int        phase_end;
    logic [31:0] rtt_pick;
    logic [63:0] timeout_pick;

    round_trip_clock_offset_sync_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_beat sync_step(input t_in_beat b);
        t_out_beat          r;
        logic [63:0]        elapsed;
        logic [63:0]        proc;
        logic [63:0]        half;
        logic signed [63:0] hrx;
        logic signed [63:0] htx;
        logic signed [63:0] lu_ns;
        logic signed [63:0] est;
        r = '0;
        hrx = b.hrx_ns;
        htx = b.htx_ns;
        elapsed = (b.loc_us - req_us) * 64'd1000;
        proc = htx - hrx;
        half = (elapsed - proc) >> 1;
        lu_ns = b.loc_us * 64'd1000;
        est = lu_ns + ofs_ns;
        case (t_op'(b.op))
            OP_START: begin
                req_us = b.loc_us;
                req_open = 1'b1;
                r.ok = 1'b1;
            end
            OP_ACCEPT: begin
                if (req_open && !b.echo_us[63] && b.echo_us == req_us
                        && b.loc_us >= req_us && b.loc_us <= LOCAL_US_LIMIT
                        && hrx > 0 && htx >= hrx && htx <= HOST_NS_TOP
                        && elapsed <= {32'd0, rtt_us} * 64'd1000 && proc <= elapsed
                        && htx <= HOST_NS_TOP - $signed(half)) begin
                    ofs_ns = htx + $signed(half) - lu_ns;
                    sync_us = b.loc_us;
                    synced = 1'b1;
                    req_open = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                if (synced && b.loc_us >= sync_us && b.loc_us - sync_us < tmo_us
                        && b.loc_us <= LOCAL_US_LIMIT
                        && !(ofs_ns > 0 && lu_ns > INT_NS_TOP - ofs_ns)
                        && est >= 0 && est <= HOST_NS_TOP) begin
                    r.ok = 1'b1;
                    r.host_time_ns = est[HOST_TIME_W-1:0];
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_beat mk(input t_op op, input logic [63:0] lu, input logic [63:0] eu,
                                    input logic [63:0] hr, input logic [63:0] hs);
        t_in_beat b;
        b.op = op;
        b.loc_us = lu;
        b.echo_us = eu;
        b.hrx_ns = hr;
        b.htx_ns = hs;
        return b;
    endfunction

    function automatic t_row row(input t_op op, input logic [63:0] lu, input logic [63:0] eu,
                                 input logic [63:0] hr, input logic [63:0] hs,
                                 input bit typed, input bit ok);
        t_row r;
        r.beat = mk(op, lu, eu, hr, hs);
        r.typed = typed;
        r.want = '0;
        r.want.ok = ok;
        return r;
    endfunction

    function automatic logic [63:0] pick_local();
        case ($urandom_range(0, 9))
            0: return LOCAL_US_LIMIT - 64'($urandom_range(0, 50));
            1: return rand64();
            default: return {32'd0, $urandom};
        endcase
    endfunction

    task automatic report_miss(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin send_gap_pct = 33; recv_stall_pct = 87; end
            1: begin send_gap_pct = 87; recv_stall_pct = 33; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    task automatic write_regs(input logic [63:0] rtt_word, input logic [63:0] timeout_word);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_MAX_RTT_US;
        cfg_data <= rtt_word;
        @(posedge i_clk);
        cfg_idx <= CFG_SYNC_TIMEOUT_US;
        cfg_data <= timeout_word;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        rtt_us = rtt_word[31:0];
        tmo_us = timeout_word;
    endtask

    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat model;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        model = sync_step(b);
        awaited.push_back(typed ? want : model);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_exchange();
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] d;
        logic [63:0] lim;
        logic [63:0] elapsed;
        logic [63:0] proc;
        logic [63:0] hrx;
        logic [63:0] echo;
        logic [63:0] tcap;
        logic [63:0] k;
        int          nq;
        t0 = pick_local();
        send_beat(mk(OP_START, t0, rand64(), rand64(), rand64()), 1'b0, '0);
        lim = (rtt_us < 32'd3000) ? {32'd0, rtt_us} : 64'd3000;
        d = ($urandom_range(0, 9) == 0) ? {32'd0, rtt_us} + 64'd1
                                        : 64'($urandom_range(0, 32'(lim)));
        t1 = t0 + d;
        elapsed = d * 64'd1000;
        proc = ($urandom_range(0, 9) == 0) ? elapsed + 64'd1 : rand64() % (elapsed + 64'd1);
        case ($urandom_range(0, 7))
            0: hrx = MAX_HOST_NS - proc - 64'($urandom_range(0, 2000));
            1: hrx = 64'($urandom_range(1, 1000));
            default: hrx = 64'd1 + rand64() % (MAX_HOST_NS - proc);
        endcase
        echo = ($urandom_range(0, 11) == 0) ? t0 ^ (64'd1 << $urandom_range(0, 63)) : t0;
        send_beat(mk(OP_ACCEPT, t1, echo, hrx, hrx + proc), 1'b0, '0);
        tcap = (tmo_us > 64'd20000) ? 64'd20000 : tmo_us;
        nq = $urandom_range(0, 4);
        for (int q = 0; q < nq; q++) begin
            case ($urandom_range(0, 7))
                0: k = '0;
                1: k = tmo_us - 64'd1;
                2: k = tmo_us;
                3: k = '1;
                default: k = 64'($urandom_range(0, 32'(tcap)));
            endcase
            send_beat(mk(OP_QUERY, t1 + k, rand64(), rand64(), rand64()), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited.size() == 0) begin
                report_miss($sformatf("result with none due: ok=%0b host_time_ns=%0d",
                                      out_beat.ok, out_beat.host_time_ns));
            end else begin
                due = awaited.pop_front();
                if (out_beat.ok !== due.ok)
                    report_miss($sformatf("ok: got %0b, want %0b", out_beat.ok, due.ok));
                if (out_beat.host_time_ns !== due.host_time_ns)
                    report_miss($sformatf("host_time_ns: got %0d, want %0d",
                                          out_beat.host_time_ns, due.host_time_ns));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        req_us = '0;
        req_open = 1'b0;
        ofs_ns = '0;
        sync_us = '0;
        synced = 1'b0;
        rtt_us = '0;
        tmo_us = '0;

        script.push_back(row(OP_QUERY, 5, 0, 0, 0, 1, 0));
        script.push_back(row(OP_NONE, '1, '1, '1, '1, 1, 0));
        script.push_back(row(OP_ACCEPT, 1000, 1000, 1, 1, 1, 0));
        script.push_back(row(OP_START, 1000, 0, 0, 0, 1, 1));
        script.push_back(row(OP_ACCEPT, 1010, 1001, 5000000, 5004000, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 64'h8000_0000_0000_03E8, 5000000, 5004000, 1, 0));
        script.push_back(row(OP_ACCEPT, 999, 1000, 5000000, 5004000, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 1000, 0, 4000, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 1000, 5000000, 4999999, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 1000, 5000000, MAX_HOST_NS + 64'd1, 1, 0));
        script.push_back(row(OP_ACCEPT, 2001, 1000, 5000000, 5004000, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 1000, 1, 20001, 1, 0));
        script.push_back(row(OP_ACCEPT, 1010, 1000, 5000000, 5004000, 1, 1));
        script.push_back(row(OP_QUERY, 1010, 0, 0, 0, 0, 0));
        script.push_back(row(OP_QUERY, 1009, 0, 0, 0, 1, 0));
        script.push_back(row(OP_QUERY, 11010, 0, 0, 0, 1, 0));
        script.push_back(row(OP_QUERY, 11009, 0, 0, 0, 0, 0));
        script.push_back(row(OP_START, 100, 0, 0, 0, 1, 1));
        script.push_back(row(OP_ACCEPT, 101, 100, MAX_HOST_NS - 100, MAX_HOST_NS - 100, 0, 0));
        script.push_back(row(OP_ACCEPT, 100, 100, MAX_HOST_NS, MAX_HOST_NS, 0, 0));
        script.push_back(row(OP_QUERY, 100, 0, 0, 0, 0, 0));
        script.push_back(row(OP_QUERY, 101, 0, 0, 0, 0, 0));
        script.push_back(row(OP_START, '1, 0, 0, 0, 1, 1));
        script.push_back(row(OP_START, LOCAL_US_LIMIT, 0, 0, 0, 1, 1));
        script.push_back(row(OP_ACCEPT, LOCAL_US_LIMIT + 64'd1, LOCAL_US_LIMIT, 1, 1, 1, 0));

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        set_pace(0);
        write_regs(64'd1000, 64'd10000);
        foreach (script[i])
            send_beat(script[i].beat, script[i].typed, script[i].want);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_pace(ph / 2);
            case (ph)
                0: begin rtt_pick = '0; timeout_pick = '1; end
                1: begin rtt_pick = '1; timeout_pick = '0; end
                default: begin
                    rtt_pick = $urandom_range(1, 5000);
                    timeout_pick = 64'($urandom_range(1, 20000));
                end
            endcase
            write_regs({$urandom, rtt_pick}, timeout_pick);
            if (ph == 4)
                hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                if ($urandom_range(0, 99) < 15)
                    send_beat(mk(t_op'(2'($urandom_range(0, 3))), rand64(), rand64(),
                                 rand64(), rand64()), 1'b0, '0);
                else
                    run_exchange();
            end
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/rtcos_pkg.sv
rtl/rtcos_prep.sv
rtl/round_trip_clock_offset_sync_unit.sv
rtl/rtcos_checker.sv
tb/testbench.sv
